// ===== rtl/adsr_pkg.sv =====
// ADSR envelope generator: shared constants and widths.
// No dependencies; used by the interfaces, the step datapath and the top level.
`timescale 1ns / 1ps

package adsr_pkg;

	localparam int LevelW = 17;
	localparam int CoeffW = 16;
	localparam int StageW = 3;
	localparam int OpW    = 2;
	localparam int ModeW  = 2;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 17;

	// Unity in Q1.16
	localparam logic [LevelW-1:0] LEVEL_ONE = 17'h10000;

	// Envelope stage codes
	localparam logic [StageW-1:0] STAGE_IDLE    = 3'd0;
	localparam logic [StageW-1:0] STAGE_ATTACK  = 3'd1;
	localparam logic [StageW-1:0] STAGE_DECAY   = 3'd2;
	localparam logic [StageW-1:0] STAGE_SUSTAIN = 3'd3;
	localparam logic [StageW-1:0] STAGE_RELEASE = 3'd4;

	// Event opcodes
	localparam logic [OpW-1:0] OP_TICK     = 2'd0;
	localparam logic [OpW-1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [OpW-1:0] OP_NOTE_OFF = 2'd2;
	localparam logic [OpW-1:0] OP_CLOCK    = 2'd3;

	// Trigger modes
	localparam logic [ModeW-1:0] MODE_GATE_TRIG = 2'd0;
	localparam logic [ModeW-1:0] MODE_ONE_SHOT  = 2'd1;
	localparam logic [ModeW-1:0] MODE_LFO_RETRIG = 2'd2;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_ATTACK_COEFF  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_DECAY_COEFF   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_RELEASE_COEFF = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SUSTAIN_LEVEL = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ATTACK_TARGET = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SNAP_THRESH   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_TRIGGER_MODE  = 3'd6;

	// Reset values
	localparam logic [LevelW-1:0] ATTACK_TARGET_RST = 17'd85197;
	localparam logic [CoeffW-1:0] SNAP_THRESH_RST   = 16'd66;

endpackage

// ===== rtl/adsr_if.sv =====
// ADSR envelope generator: valid/ready channel interfaces for events and results.
// Depends on adsr_pkg for field widths.
`timescale 1ns / 1ps

interface adsr_evt_if;
	logic                         valid;
	logic                         ready;
	logic [adsr_pkg::OpW-1:0]     opcode;
	logic                         legato;

	modport source (output valid, output opcode, output legato, input ready);
	modport sink   (input valid, input opcode, input legato, output ready);
endinterface

interface adsr_env_if;
	logic                          valid;
	logic                          ready;
	logic [adsr_pkg::LevelW-1:0]   level;
	logic [adsr_pkg::StageW-1:0]   stage;

	modport source (output valid, output level, output stage, input ready);
	modport sink   (input valid, input level, input stage, output ready);
endinterface

// ===== rtl/adsr_approach.sv =====
// One-pole approach step: level + floor((target - level) * (1 - coeff)), Q1.16.
// Depends on adsr_pkg.
`timescale 1ns / 1ps

module adsr_approach (
	input  logic [adsr_pkg::LevelW-1:0] level,
	input  logic [adsr_pkg::LevelW-1:0] target,
	input  logic [adsr_pkg::CoeffW-1:0] coeff,
	output logic [adsr_pkg::LevelW-1:0] result
);

	logic signed [adsr_pkg::LevelW:0]         delta;
	logic        [adsr_pkg::LevelW-1:0]       gain;
	logic signed [adsr_pkg::LevelW:0]         gain_s;
	logic signed [2*adsr_pkg::LevelW+1:0]     prod;
	logic signed [2*adsr_pkg::LevelW-adsr_pkg::CoeffW+1:0] step;
	logic signed [2*adsr_pkg::LevelW-adsr_pkg::CoeffW+1:0] sum;

	assign delta  = signed'({1'b0, target}) - signed'({1'b0, level});
	assign gain   = adsr_pkg::LEVEL_ONE - {1'b0, coeff};
	assign gain_s = signed'({1'b0, gain});
	assign prod   = delta * gain_s;
	// arithmetic shift floors toward minus infinity
	assign step   = prod[2*adsr_pkg::LevelW+1:adsr_pkg::CoeffW];
	assign sum    = signed'({3'b000, level}) + step;
	assign result = sum[adsr_pkg::LevelW-1:0];

endmodule

// ===== rtl/adsr_envelope_generator_top.sv =====
// ADSR envelope generator top level: event register, stage/level state, result register.
// Depends on adsr_pkg, adsr_if (adsr_evt_if, adsr_env_if) and adsr_approach.
`timescale 1ns / 1ps

// Usage:
//   evt  - event channel (opcode: tick, note on, note off, LFO clock; legato flag).
//   env  - result channel, one transfer per event: level (Q1.16) and stage after it.
//   cfg_wr_en/cfg_index/cfg_data - register writes, taken on any edge with cfg_wr_en high;
//   write only while no event is in flight.
// An accepted event passes through the event register, then the result register,
// before it is presented on env.
// Throughput: one event per cycle while env is taken. The stage/level state is updated
// when an event leaves the event register, so the next event already sees it, no gap.
// The update path is one 18x18 multiply and an add in adsr_approach, then compares here.
// Stall: when env is not taken, the result register holds and the event register
// fills; evt.ready drops only when both are full.
// Reset: stage idle, level 0, registers to their documented reset values,
// both pipeline registers empty.
module adsr_envelope_generator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	adsr_evt_if.sink                      evt,
	adsr_env_if.source                    env,
	input  logic                          cfg_wr_en,
	input  logic [adsr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [adsr_pkg::CfgDataW-1:0] cfg_data
);

	// configuration
	logic [adsr_pkg::CoeffW-1:0] attack_coeff_q, decay_coeff_q, release_coeff_q;
	logic [adsr_pkg::LevelW-1:0] sustain_q, attack_target_q;
	logic [adsr_pkg::CoeffW-1:0] snap_q;
	logic [adsr_pkg::ModeW-1:0]  mode_q;
	logic [adsr_pkg::LevelW-1:0] sustain_clamped;

	// envelope state
	logic [adsr_pkg::StageW-1:0] stage_q;
	logic [adsr_pkg::LevelW-1:0] level_q;

	// event register
	logic                        valid_s1;
	logic [adsr_pkg::OpW-1:0]    opcode_s1;
	logic                        legato_s1;

	// result register
	logic                        out_valid_q;
	logic [adsr_pkg::LevelW-1:0] out_level_q;
	logic [adsr_pkg::StageW-1:0] out_stage_q;

	logic                        advance;
	logic [adsr_pkg::LevelW-1:0] seg_target;
	logic [adsr_pkg::CoeffW-1:0] seg_coeff;
	logic [adsr_pkg::LevelW-1:0] approached;
	logic [adsr_pkg::LevelW-1:0] sus_dist;
	logic [adsr_pkg::StageW-1:0] nxt_stage;
	logic [adsr_pkg::LevelW-1:0] nxt_level;

	assign advance   = valid_s1 && (!out_valid_q || env.ready);
	assign evt.ready = !valid_s1 || advance;

	assign env.valid = out_valid_q;
	assign env.level = out_level_q;
	assign env.stage = out_stage_q;

	assign sustain_clamped = (cfg_data > adsr_pkg::LEVEL_ONE) ? adsr_pkg::LEVEL_ONE : cfg_data;

	// segment selection follows the current stage
	always_comb begin
		case (stage_q)
			adsr_pkg::STAGE_ATTACK: begin
				seg_target = attack_target_q;
				seg_coeff  = attack_coeff_q;
			end
			adsr_pkg::STAGE_DECAY: begin
				seg_target = sustain_q;
				seg_coeff  = decay_coeff_q;
			end
			default: begin
				seg_target = '0;
				seg_coeff  = release_coeff_q;
			end
		endcase
	end

	adsr_approach u_approach (
		.level  (level_q),
		.target (seg_target),
		.coeff  (seg_coeff),
		.result (approached)
	);

	assign sus_dist = (approached >= sustain_q) ? approached - sustain_q
	                                            : sustain_q - approached;

	always_comb begin
		nxt_stage = stage_q;
		nxt_level = level_q;
		case (opcode_s1)
			adsr_pkg::OP_TICK: begin
				case (stage_q)
					adsr_pkg::STAGE_ATTACK: begin
						if (approached >= adsr_pkg::LEVEL_ONE) begin
							nxt_level = adsr_pkg::LEVEL_ONE;
							nxt_stage = adsr_pkg::STAGE_DECAY;
						end else begin
							nxt_level = approached;
						end
					end
					adsr_pkg::STAGE_DECAY: begin
						if (sus_dist <= {1'b0, snap_q}) begin
							nxt_level = sustain_q;
							nxt_stage = adsr_pkg::STAGE_SUSTAIN;
						end else begin
							nxt_level = approached;
						end
					end
					adsr_pkg::STAGE_SUSTAIN: begin
						nxt_level = sustain_q;
					end
					adsr_pkg::STAGE_RELEASE: begin
						if (approached <= {1'b0, snap_q}) begin
							nxt_level = '0;
							nxt_stage = adsr_pkg::STAGE_IDLE;
						end else begin
							nxt_level = approached;
						end
					end
					default: ;
				endcase
			end
			adsr_pkg::OP_NOTE_ON: begin
				case (mode_q)
					adsr_pkg::MODE_GATE_TRIG: nxt_stage = adsr_pkg::STAGE_ATTACK;
					adsr_pkg::MODE_ONE_SHOT: begin
						if (stage_q == adsr_pkg::STAGE_IDLE || !legato_s1)
							nxt_stage = adsr_pkg::STAGE_ATTACK;
					end
					adsr_pkg::MODE_LFO_RETRIG: begin
						if (stage_q == adsr_pkg::STAGE_IDLE)
							nxt_stage = adsr_pkg::STAGE_ATTACK;
					end
					default: ;
				endcase
			end
			adsr_pkg::OP_NOTE_OFF: begin
				if (stage_q != adsr_pkg::STAGE_IDLE)
					nxt_stage = adsr_pkg::STAGE_RELEASE;
			end
			adsr_pkg::OP_CLOCK: begin
				if (mode_q == adsr_pkg::MODE_LFO_RETRIG)
					nxt_stage = adsr_pkg::STAGE_ATTACK;
			end
			default: ;
		endcase
	end

	// configuration and envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_coeff_q  <= '0;
			decay_coeff_q   <= '0;
			release_coeff_q <= '0;
			sustain_q       <= '0;
			attack_target_q <= adsr_pkg::ATTACK_TARGET_RST;
			snap_q          <= adsr_pkg::SNAP_THRESH_RST;
			mode_q          <= adsr_pkg::MODE_GATE_TRIG;
			stage_q         <= adsr_pkg::STAGE_IDLE;
			level_q         <= '0;
		end else begin
			if (advance) begin
				stage_q <= nxt_stage;
				level_q <= nxt_level;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					adsr_pkg::REG_ATTACK_COEFF:  attack_coeff_q  <= cfg_data[adsr_pkg::CoeffW-1:0];
					adsr_pkg::REG_DECAY_COEFF:   decay_coeff_q   <= cfg_data[adsr_pkg::CoeffW-1:0];
					adsr_pkg::REG_RELEASE_COEFF: release_coeff_q <= cfg_data[adsr_pkg::CoeffW-1:0];
					adsr_pkg::REG_SUSTAIN_LEVEL: begin
						sustain_q <= sustain_clamped;
						// sustaining envelope follows the new level at once
						if (stage_q == adsr_pkg::STAGE_SUSTAIN)
							level_q <= sustain_clamped;
					end
					adsr_pkg::REG_ATTACK_TARGET: attack_target_q <= cfg_data;
					adsr_pkg::REG_SNAP_THRESH:   snap_q <= cfg_data[adsr_pkg::CoeffW-1:0];
					adsr_pkg::REG_TRIGGER_MODE:  mode_q <= cfg_data[adsr_pkg::ModeW-1:0];
					default: ;
				endcase
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt.ready)
				valid_s1 <= evt.valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (env.ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			opcode_s1 <= evt.opcode;
			legato_s1 <= evt.legato;
		end
		if (advance) begin
			out_level_q <= nxt_level;
			out_stage_q <= nxt_stage;
		end
	end

	a_idle_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == adsr_pkg::STAGE_IDLE |-> level_q == '0)
		else $error("idle stage with nonzero level");

	a_sustain_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == adsr_pkg::STAGE_SUSTAIN |-> level_q == sustain_q)
		else $error("sustain stage level differs from sustain register");

	a_level_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= adsr_pkg::LEVEL_ONE)
		else $error("envelope level above unity");

	a_event_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(opcode_s1) && $stable(legato_s1))
		else $error("pending event lost or changed while stalled");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for adsr_envelope_generator_top: event stream in, level/stage out.
// Depends on adsr_pkg and the adsr_evt_if / adsr_env_if channel interfaces.
`timescale 1ns / 1ps

module tb;

	// trigger mode code 3 and register index 7 have no function in the block
	localparam logic [adsr_pkg::ModeW-1:0]   MODE_UNUSED  = 2'd3;
	localparam logic [adsr_pkg::CfgIdxW-1:0] REG_UNMAPPED = 3'd7;
	localparam int NUM_DIR  = 39;
	localparam int NUM_SEGS = 16;
	localparam int SEG_LEN  = 53;

	typedef struct {
		logic [adsr_pkg::LevelW-1:0] level;
		logic [adsr_pkg::StageW-1:0] stage;
	} env_res_t;

	typedef struct {
		bit       typed;
		env_res_t res;
	} fixed_exp_t;

	typedef struct {
		bit                            is_cfg;
		logic [adsr_pkg::CfgIdxW-1:0]  idx;
		logic [adsr_pkg::CfgDataW-1:0] data;
		logic [adsr_pkg::OpW-1:0]      op;
		logic                          leg;
		bit                            typed;
		env_res_t                      res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [adsr_pkg::CfgIdxW-1:0]  cfg_index;
	logic [adsr_pkg::CfgDataW-1:0] cfg_data;

	adsr_evt_if evt_ch();
	adsr_env_if env_ch();

	adsr_envelope_generator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_ch),
		.env       (env_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// envelope state and register copy kept by the bench
	logic [adsr_pkg::StageW-1:0] env_stage  = adsr_pkg::STAGE_IDLE;
	logic [adsr_pkg::LevelW-1:0] env_level  = '0;
	logic [adsr_pkg::CoeffW-1:0] atk_coeff  = '0;
	logic [adsr_pkg::CoeffW-1:0] dec_coeff  = '0;
	logic [adsr_pkg::CoeffW-1:0] rel_coeff  = '0;
	logic [adsr_pkg::LevelW-1:0] sus_level  = '0;
	logic [adsr_pkg::LevelW-1:0] atk_target = adsr_pkg::ATTACK_TARGET_RST;
	logic [adsr_pkg::CoeffW-1:0] snap_thr   = adsr_pkg::SNAP_THRESH_RST;
	logic [adsr_pkg::ModeW-1:0]  trig_mode  = adsr_pkg::MODE_GATE_TRIG;

	env_res_t   env_expect_q[$];
	fixed_exp_t row_check_q[$];
	env_res_t   no_res = '{level: '0, stage: '0};

	int items_sent   = 0;
	int results_seen = 0;
	int error_count  = 0;
	int tx_idle_pct  = 0;
	int rx_idle_pct;
	int seg_no       = -1;
	logic rx_hold    = 1'b0;

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// one-pole step, product floored toward minus infinity
	function automatic longint one_pole_step(input longint lvl, input longint tgt,
						input longint coeff);
		longint prod;
		prod = (tgt - lvl) * (longint'(65536) - coeff);
		if (prod >= 0) begin
			return lvl + prod / 65536;
		end
		return lvl - ((-prod + 65535) / 65536);
	endfunction

	function automatic void advance_envelope();
		longint nxt, gap, sus, thr, one;
		sus = sus_level;
		thr = snap_thr;
		one = adsr_pkg::LEVEL_ONE;
		case (env_stage)
			adsr_pkg::STAGE_ATTACK: begin
				nxt = one_pole_step(env_level, atk_target, atk_coeff);
				if (nxt >= one) begin
					env_level = adsr_pkg::LEVEL_ONE;
					env_stage = adsr_pkg::STAGE_DECAY;
				end else begin
					env_level = nxt[adsr_pkg::LevelW-1:0];
				end
			end
			adsr_pkg::STAGE_DECAY: begin
				nxt = one_pole_step(env_level, sus_level, dec_coeff);
				gap = nxt - sus;
				if (gap < 0) gap = -gap;
				if (gap <= thr) begin
					env_level = sus_level;
					env_stage = adsr_pkg::STAGE_SUSTAIN;
				end else begin
					env_level = nxt[adsr_pkg::LevelW-1:0];
				end
			end
			adsr_pkg::STAGE_SUSTAIN: begin
				env_level = sus_level;
			end
			adsr_pkg::STAGE_RELEASE: begin
				nxt = one_pole_step(env_level, 0, rel_coeff);
				if (nxt <= thr) begin
					env_level = '0;
					env_stage = adsr_pkg::STAGE_IDLE;
				end else begin
					env_level = nxt[adsr_pkg::LevelW-1:0];
				end
			end
			default: ;
		endcase
	endfunction

	function automatic env_res_t apply_event(input logic [adsr_pkg::OpW-1:0] op,
						 input logic leg);
		env_res_t r;
		case (op)
			adsr_pkg::OP_TICK: advance_envelope();
			adsr_pkg::OP_NOTE_ON: begin
				if (trig_mode == adsr_pkg::MODE_GATE_TRIG) begin
					env_stage = adsr_pkg::STAGE_ATTACK;
				end else if (trig_mode == adsr_pkg::MODE_ONE_SHOT) begin
					if (env_stage == adsr_pkg::STAGE_IDLE || !leg)
						env_stage = adsr_pkg::STAGE_ATTACK;
				end else if (trig_mode == adsr_pkg::MODE_LFO_RETRIG) begin
					if (env_stage == adsr_pkg::STAGE_IDLE)
						env_stage = adsr_pkg::STAGE_ATTACK;
				end
			end
			adsr_pkg::OP_NOTE_OFF: begin
				if (env_stage != adsr_pkg::STAGE_IDLE) env_stage = adsr_pkg::STAGE_RELEASE;
			end
			adsr_pkg::OP_CLOCK: begin
				if (trig_mode == adsr_pkg::MODE_LFO_RETRIG)
					env_stage = adsr_pkg::STAGE_ATTACK;
			end
			default: ;
		endcase
		r.level = env_level;
		r.stage = env_stage;
		return r;
	endfunction

	function automatic void apply_reg_write(input logic [adsr_pkg::CfgIdxW-1:0] idx,
						input logic [adsr_pkg::CfgDataW-1:0] val);
		case (idx)
			adsr_pkg::REG_ATTACK_COEFF:  atk_coeff = val[adsr_pkg::CoeffW-1:0];
			adsr_pkg::REG_DECAY_COEFF:   dec_coeff = val[adsr_pkg::CoeffW-1:0];
			adsr_pkg::REG_RELEASE_COEFF: rel_coeff = val[adsr_pkg::CoeffW-1:0];
			adsr_pkg::REG_SUSTAIN_LEVEL: begin
				sus_level = (val > adsr_pkg::LEVEL_ONE) ? adsr_pkg::LEVEL_ONE : val;
				if (env_stage == adsr_pkg::STAGE_SUSTAIN) env_level = sus_level;
			end
			adsr_pkg::REG_ATTACK_TARGET: atk_target = val;
			adsr_pkg::REG_SNAP_THRESH:   snap_thr = val[adsr_pkg::CoeffW-1:0];
			adsr_pkg::REG_TRIGGER_MODE:  trig_mode = val[adsr_pkg::ModeW-1:0];
			default: ;
		endcase
	endfunction

	// results are checked before the same edge's event transfer is predicted
	always @(posedge clk) begin : scoreboard
		env_res_t want;
		fixed_exp_t tag;
		if (arst_n) begin
			if (cfg_wr_en) apply_reg_write(cfg_index, cfg_data);
			if (env_ch.valid && env_ch.ready) begin
				if (env_expect_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result level %0d stage %0d",
						env_ch.level, env_ch.stage));
				end else begin
					want = env_expect_q.pop_front();
					results_seen++;
					if (env_ch.level !== want.level)
						report_mismatch($sformatf("result %0d level got %0d want %0d",
							results_seen, env_ch.level, want.level));
					if (env_ch.stage !== want.stage)
						report_mismatch($sformatf("result %0d stage got %0d want %0d",
							results_seen, env_ch.stage, want.stage));
				end
			end
			if (evt_ch.valid && evt_ch.ready) begin
				tag = row_check_q.pop_front();
				want = apply_event(evt_ch.opcode, evt_ch.legato);
				if (tag.typed) want = tag.res;
				env_expect_q.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		env_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		wait (seg_no == 13);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (80) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_event(input logic [adsr_pkg::OpW-1:0] op, input logic leg,
				  input bit typed, input env_res_t res);
		fixed_exp_t tag;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tag.typed = typed;
		tag.res = res;
		row_check_q.push_back(tag);
		evt_ch.valid  <= 1'b1;
		evt_ch.opcode <= op;
		evt_ch.legato <= leg;
		do @(posedge clk); while (!evt_ch.ready);
		items_sent++;
	endtask

	task automatic send_random();
		send_event(adsr_pkg::OpW'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0,
			   no_res);
	endtask

	task automatic wait_idle();
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (results_seen != items_sent);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [adsr_pkg::CfgIdxW-1:0] idx,
				 input logic [adsr_pkg::CfgDataW-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [adsr_pkg::CfgDataW-1:0] pick_coeff();
		logic [adsr_pkg::CfgDataW-1:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = 17'h0FFFF;
			default: v = adsr_pkg::CfgDataW'($urandom_range(16000, 62000));
		endcase
		v[adsr_pkg::CfgDataW-1] = 1'($urandom_range(0, 1));
		return v;
	endfunction

	// note-on, a run of ticks, note-off, another run; noise mixed in
	task automatic play_notes(input int n);
		int start, k;
		start = items_sent;
		while (items_sent - start < n) begin
			if ($urandom_range(0, 4) == 0) begin
				send_random();
			end else begin
				send_event(adsr_pkg::OP_NOTE_ON, 1'($urandom_range(0, 1)), 1'b0, no_res);
				k = $urandom_range(1, 30);
				while (k > 0 && items_sent - start < n) begin
					if ($urandom_range(0, 11) == 0) send_random();
					else send_event(adsr_pkg::OP_TICK, 1'($urandom_range(0, 1)), 1'b0,
							no_res);
					k--;
				end
				if (items_sent - start < n)
					send_event(adsr_pkg::OP_NOTE_OFF, 1'($urandom_range(0, 1)), 1'b0,
						   no_res);
				k = $urandom_range(1, 30);
				while (k > 0 && items_sent - start < n) begin
					send_event(adsr_pkg::OP_TICK, 1'($urandom_range(0, 1)), 1'b0, no_res);
					k--;
				end
			end
		end
	endtask

	function automatic dir_row_t ev_row(input logic [adsr_pkg::OpW-1:0] op, input logic leg);
		dir_row_t r;
		r.is_cfg = 1'b0; r.idx = '0; r.data = '0;
		r.op = op; r.leg = leg;
		r.typed = 1'b0; r.res = no_res;
		return r;
	endfunction

	function automatic dir_row_t chk_row(input logic [adsr_pkg::OpW-1:0] op, input logic leg,
					     input logic [adsr_pkg::LevelW-1:0] lvl,
					     input logic [adsr_pkg::StageW-1:0] stg);
		dir_row_t r;
		r.is_cfg = 1'b0; r.idx = '0; r.data = '0;
		r.op = op; r.leg = leg;
		r.typed = 1'b1; r.res.level = lvl; r.res.stage = stg;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input logic [adsr_pkg::CfgIdxW-1:0] idx,
					     input logic [adsr_pkg::CfgDataW-1:0] val);
		dir_row_t r;
		r.is_cfg = 1'b1; r.idx = idx; r.data = val;
		r.op = adsr_pkg::OP_TICK; r.leg = 1'b0;
		r.typed = 1'b0; r.res = no_res;
		return r;
	endfunction

	initial begin
		dir_row_t dir_tab[NUM_DIR];
		logic [adsr_pkg::CfgDataW-1:0] val;
		logic [adsr_pkg::ModeW-1:0] mode;
		int i, seg;

		arst_n        = 1'b0;
		evt_ch.valid  = 1'b0;
		evt_ch.opcode = adsr_pkg::OP_TICK;
		evt_ch.legato = 1'b0;
		env_ch.ready  = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		rx_idle_pct   = 0;

		// starts from reset registers: all coefficients zero, sustain zero
		dir_tab = '{
			chk_row(adsr_pkg::OP_TICK,     1'b0, 17'd0, adsr_pkg::STAGE_IDLE),
			chk_row(adsr_pkg::OP_NOTE_OFF, 1'b1, 17'd0, adsr_pkg::STAGE_IDLE),
			chk_row(adsr_pkg::OP_CLOCK,    1'b1, 17'd0, adsr_pkg::STAGE_IDLE),
			chk_row(adsr_pkg::OP_NOTE_ON,  1'b1, 17'd0, adsr_pkg::STAGE_ATTACK),
			chk_row(adsr_pkg::OP_TICK, 1'b0, adsr_pkg::LEVEL_ONE, adsr_pkg::STAGE_DECAY),
			chk_row(adsr_pkg::OP_TICK,     1'b0, 17'd0, adsr_pkg::STAGE_SUSTAIN),
			// sustain rewritten while sustaining, above unity
			cfg_row(adsr_pkg::REG_SUSTAIN_LEVEL, 17'h1FFFF),
			chk_row(adsr_pkg::OP_TICK, 1'b0, adsr_pkg::LEVEL_ONE, adsr_pkg::STAGE_SUSTAIN),
			chk_row(adsr_pkg::OP_NOTE_OFF, 1'b0, adsr_pkg::LEVEL_ONE,
				adsr_pkg::STAGE_RELEASE),
			chk_row(adsr_pkg::OP_TICK,     1'b1, 17'd0, adsr_pkg::STAGE_IDLE),
			cfg_row(adsr_pkg::REG_TRIGGER_MODE,
				adsr_pkg::CfgDataW'(adsr_pkg::MODE_LFO_RETRIG)),
			chk_row(adsr_pkg::OP_NOTE_ON,  1'b0, 17'd0, adsr_pkg::STAGE_ATTACK),
			ev_row(adsr_pkg::OP_NOTE_ON, 1'b1),
			ev_row(adsr_pkg::OP_CLOCK, 1'b0),
			cfg_row(adsr_pkg::REG_ATTACK_COEFF, 17'h0FFFF),
			chk_row(adsr_pkg::OP_TICK,     1'b0, 17'd1, adsr_pkg::STAGE_ATTACK),
			cfg_row(adsr_pkg::REG_TRIGGER_MODE,
				adsr_pkg::CfgDataW'(adsr_pkg::MODE_ONE_SHOT)),
			ev_row(adsr_pkg::OP_NOTE_OFF, 1'b0),
			ev_row(adsr_pkg::OP_NOTE_ON, 1'b1),
			ev_row(adsr_pkg::OP_NOTE_ON, 1'b0),
			cfg_row(adsr_pkg::REG_TRIGGER_MODE, adsr_pkg::CfgDataW'(MODE_UNUSED)),
			ev_row(adsr_pkg::OP_NOTE_OFF, 1'b1),
			ev_row(adsr_pkg::OP_NOTE_ON, 1'b0),
			ev_row(adsr_pkg::OP_CLOCK, 1'b1),
			cfg_row(adsr_pkg::REG_TRIGGER_MODE,
				adsr_pkg::CfgDataW'(adsr_pkg::MODE_GATE_TRIG)),
			ev_row(adsr_pkg::OP_NOTE_ON, 1'b0),
			// bit 16 of a coefficient write is dropped
			cfg_row(adsr_pkg::REG_ATTACK_COEFF, 17'h10000),
			// attack target below unity: stays in attack
			cfg_row(adsr_pkg::REG_ATTACK_TARGET, 17'd65535),
			chk_row(adsr_pkg::OP_TICK,     1'b0, 17'd65535, adsr_pkg::STAGE_ATTACK),
			cfg_row(adsr_pkg::REG_ATTACK_TARGET, 17'h1FFFF),
			cfg_row(adsr_pkg::REG_DECAY_COEFF, 17'h0FFFF),
			cfg_row(adsr_pkg::REG_SNAP_THRESH, 17'h1FFFF),
			cfg_row(adsr_pkg::REG_SUSTAIN_LEVEL, 17'd0),
			chk_row(adsr_pkg::OP_TICK, 1'b0, adsr_pkg::LEVEL_ONE, adsr_pkg::STAGE_DECAY),
			ev_row(adsr_pkg::OP_TICK, 1'b1),
			cfg_row(adsr_pkg::REG_RELEASE_COEFF, 17'h0FFFF),
			cfg_row(REG_UNMAPPED, 17'h1FFFF),
			ev_row(adsr_pkg::OP_NOTE_OFF, 1'b0),
			ev_row(adsr_pkg::OP_TICK, 1'b0)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < NUM_DIR; i++) begin
			if (dir_tab[i].is_cfg) begin
				wait_idle();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				send_event(dir_tab[i].op, dir_tab[i].leg, dir_tab[i].typed, dir_tab[i].res);
			end
		end

		for (seg = 0; seg < NUM_SEGS; seg++) begin
			wait_idle();
			if (seg < 6) begin
				tx_idle_pct = 6;
				rx_idle_pct <= 85;
			end else if (seg < 12) begin
				tx_idle_pct = 85;
				rx_idle_pct <= 6;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			write_reg(adsr_pkg::REG_ATTACK_COEFF, pick_coeff());
			write_reg(adsr_pkg::REG_DECAY_COEFF, pick_coeff());
			write_reg(adsr_pkg::REG_RELEASE_COEFF, pick_coeff());
			case ($urandom_range(0, 5))
				0: val = '0;
				1: val = adsr_pkg::LEVEL_ONE;
				2: val = adsr_pkg::CfgDataW'($urandom_range(65537, 131071));
				default: val = adsr_pkg::CfgDataW'($urandom_range(0, 65536));
			endcase
			write_reg(adsr_pkg::REG_SUSTAIN_LEVEL, val);
			case ($urandom_range(0, 5))
				0: val = adsr_pkg::CfgDataW'($urandom_range(0, 65536));
				1: val = 17'h1FFFF;
				2: val = 17'd65537;
				default: val = adsr_pkg::CfgDataW'($urandom_range(65537, 131071));
			endcase
			write_reg(adsr_pkg::REG_ATTACK_TARGET, val);
			case ($urandom_range(0, 5))
				0: val = '0;
				1: val = adsr_pkg::CfgDataW'($urandom_range(0, 131071));
				default: val = adsr_pkg::CfgDataW'($urandom_range(0, 1500));
			endcase
			write_reg(adsr_pkg::REG_SNAP_THRESH, val);
			case ($urandom_range(0, 9))
				0, 1, 2: mode = adsr_pkg::MODE_GATE_TRIG;
				3, 4, 5: mode = adsr_pkg::MODE_ONE_SHOT;
				6, 7, 8: mode = adsr_pkg::MODE_LFO_RETRIG;
				default: mode = MODE_UNUSED;
			endcase
			write_reg(adsr_pkg::REG_TRIGGER_MODE, {15'($urandom()), mode});
			seg_no = seg;
			play_notes(SEG_LEN);
		end

		evt_ch.valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/adsr_pkg.sv
rtl/adsr_if.sv
rtl/adsr_approach.sv
rtl/adsr_envelope_generator_top.sv
tb/tb.sv
